[rtl/elci_pkg.sv]
// Shared types and constants for the edge list to CSR incidence builder.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package elci_pkg;

   // Fixed field widths of the channels and the row count register
   localparam int OP_W     = 3;
   localparam int END_W    = 10;
   localparam int IDX_W    = 12;
   localparam int VAL_W    = 13;
   localparam int STS_W    = 2;
   localparam int ROWCNT_W = 11;

   localparam logic [ROWCNT_W-1:0] ROWCNT_RESET = 11'd1024;

   // Command codes carried in the op field
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_ADD      = 3'd1,
      OP_BUILD    = 3'd2,
      OP_READ_OFF = 3'd3,
      OP_READ_INC = 3'd4
   } op_type;

   // Result status codes
   typedef enum logic [STS_W-1:0] {
      STS_OK      = 2'd0,
      STS_RANGE   = 2'd1,
      STS_FULL    = 2'd2,
      STS_INVALID = 2'd3
   } sts_type;

   // Source of the result value
   typedef enum logic [1:0] {
      VSEL_ZERO,
      VSEL_OFFSET,
      VSEL_INCID
   } vsel_type;

   // Which endpoint of the current edge is being worked on
   typedef enum logic {
      END_A,
      END_B
   } end_type;

   // Controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EMIT,
      ST_CLEAR,
      ST_CNT_EDGE,
      ST_CNT_RD_A,
      ST_CNT_WR_A,
      ST_CNT_RD_B,
      ST_CNT_WR_B,
      ST_PRE_RD,
      ST_PRE_WR,
      ST_SCT_EDGE,
      ST_SCT_RD_A,
      ST_SCT_WR_A,
      ST_SCT_RD_B,
      ST_SCT_WR_B
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic     clear_store;
      logic     add_edge;
      logic     mark_bad;
      logic     set_built;
      logic     clr_built;
      logic     read_off;
      logic     read_inc;
      logic     walk_rst;
      logic     walk_inc;
      logic     off_zero;
      logic     edge_rd;
      end_type  end_sel;
      logic     cnt_rd;
      logic     cnt_wr;
      logic     pre_rd;
      logic     pre_wr;
      logic     sct_rd;
      logic     sct_wr;
      logic     res_load;
      sts_type  res_status;
      vsel_type res_sel;
      logic     out_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic store_full;
      logic add_out_of_range;
      logic edge_out_of_range;
      logic off_idx_ok;
      logic inc_idx_ok;
      logic bad_seen;
      logic walk_at_rows;
      logic walk_at_edges;
   } stat_type;

endpackage

[rtl/elci_req_if.sv]
// Request channel of the incidence builder: valid, ready and the command beat.
// Depends on elci_pkg for the field widths.
`timescale 1ns / 1ps

interface elci_req_if;
   import elci_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [END_W-1:0] endpoint_a;
   logic [END_W-1:0] endpoint_b;
   logic [IDX_W-1:0] read_index;

   modport source (output valid, op, endpoint_a, endpoint_b, read_index, input ready);
   modport sink (input valid, op, endpoint_a, endpoint_b, read_index, output ready);

endinterface

[rtl/elci_rsp_if.sv]
// Response channel of the incidence builder: valid, ready and the result beat.
// Depends on elci_pkg for the field widths.
`timescale 1ns / 1ps

interface elci_rsp_if;
   import elci_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] read_value;
   logic [STS_W-1:0] status;

   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);

endinterface

[rtl/elci_dp.sv]
// Datapath of the incidence builder: edge store, offset, cursor and incidence
// memories, walk counter, row count register and the result register. Uses elci_pkg.
`timescale 1ns / 1ps

module elci_dp #(
   parameter int ROWS_MAX  = 1024,
   parameter int EDGES_MAX = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [elci_pkg::ROWCNT_W-1:0]   csr_write_data,
   input  logic [elci_pkg::END_W-1:0]      req_endpoint_a,
   input  logic [elci_pkg::END_W-1:0]      req_endpoint_b,
   input  logic [elci_pkg::IDX_W-1:0]      req_read_index,
   input  elci_pkg::cmd_type               cmd,
   output elci_pkg::stat_type              stat,
   output logic [elci_pkg::VAL_W-1:0]      rsp_read_value,
   output logic [elci_pkg::STS_W-1:0]      rsp_status
);
   import elci_pkg::*;

   localparam int RCW = $clog2(ROWS_MAX + 1);                     // rows in use, offset address
   localparam int RAW = $clog2(ROWS_MAX);                         // row address
   localparam int ECW = $clog2(EDGES_MAX + 1);                    // edge count
   localparam int EAW = (EDGES_MAX > 1) ? $clog2(EDGES_MAX) : 1;  // edge number
   localparam int IAW = $clog2(2 * EDGES_MAX);                    // incidence address
   localparam int OVW = $clog2(2 * EDGES_MAX + 1);                // offset value
   localparam int WKW = (RCW > ECW) ? RCW : ECW;                  // walk counter

   logic [ROWCNT_W-1:0] row_count_ff, row_count_in;
   logic [ECW-1:0]      loaded_ff, loaded_in;
   logic                bad_ff, bad_in;
   logic                built_ff, built_in;
   logic [WKW-1:0]      walk_ff, walk_in;
   logic [OVW-1:0]      sum_ff, sum_in;
   sts_type             res_status_ff, res_status_in;
   vsel_type            res_sel_ff, res_sel_in;
   logic [VAL_W-1:0]    out_value_ff, out_value_in;
   sts_type             out_status_ff, out_status_in;

   logic [RCW-1:0]      rows;
   logic [RAW-1:0]      end_row;
   logic [RCW-1:0]      end_up;
   logic [RCW-1:0]      walk_up;
   logic [OVW-1:0]      sum_next;

   // Memories and their registered read data
   logic [2*RAW-1:0]    edge_mem [EDGES_MAX];
   logic [RAW-1:0]      edge_a_ff, edge_b_ff;
   logic [OVW-1:0]      off_mem [ROWS_MAX + 1];
   logic [OVW-1:0]      off_rd_ff;
   logic [OVW-1:0]      cur_mem [ROWS_MAX];
   logic [OVW-1:0]      cur_rd_ff;
   logic [EAW-1:0]      inc_mem [2 * EDGES_MAX];
   logic [EAW-1:0]      inc_rd_ff;

   logic                off_re, off_we;
   logic [RCW-1:0]      off_rd_addr, off_wr_addr;
   logic [OVW-1:0]      off_wr_data;
   logic                cur_we;
   logic [RAW-1:0]      cur_wr_addr;
   logic [OVW-1:0]      cur_wr_data;

   // Clamp the row count to the table size
   assign rows = (32'(row_count_ff) > 32'(ROWS_MAX)) ? RCW'(ROWS_MAX) : RCW'(row_count_ff);

   assign end_row  = (cmd.end_sel == END_A) ? edge_a_ff : edge_b_ff;
   assign end_up   = RCW'(32'(end_row) + 32'd1);
   assign walk_up  = RCW'(32'(walk_ff) + 32'd1);
   assign sum_next = sum_ff + off_rd_ff;

   // Status toward the controller
   always_comb begin
      stat.store_full        = (loaded_ff == ECW'(EDGES_MAX));
      stat.add_out_of_range  = (32'(req_endpoint_a) >= 32'(rows)) ||
                               (32'(req_endpoint_b) >= 32'(rows));
      stat.edge_out_of_range = (32'(edge_a_ff) >= 32'(rows)) ||
                               (32'(edge_b_ff) >= 32'(rows));
      stat.off_idx_ok        = built_ff && (32'(req_read_index) <= 32'(rows));
      stat.inc_idx_ok        = built_ff && (32'(req_read_index) < (32'(loaded_ff) << 1));
      stat.bad_seen          = bad_ff;
      stat.walk_at_rows      = (32'(walk_ff) == 32'(rows));
      stat.walk_at_edges     = (32'(walk_ff) == 32'(loaded_ff));
   end

   // Next values of the state registers
   always_comb begin
      row_count_in  = row_count_ff;
      loaded_in     = loaded_ff;
      bad_in        = bad_ff;
      built_in      = built_ff;
      walk_in       = walk_ff;
      sum_in        = sum_ff;
      res_status_in = res_status_ff;
      res_sel_in    = res_sel_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;

      if (cmd.clear_store) begin
         loaded_in = '0;
         bad_in    = 1'b0;
         built_in  = 1'b0;
      end
      if (cmd.add_edge) begin
         loaded_in = loaded_ff + ECW'(1);
         built_in  = 1'b0;
      end
      if (cmd.mark_bad) begin
         bad_in = 1'b1;
      end
      if (cmd.clr_built) begin
         built_in = 1'b0;
      end
      if (cmd.set_built) begin
         built_in = 1'b1;
      end
      // a row count write invalidates the table
      if (csr_write_en) begin
         row_count_in = csr_write_data;
         built_in     = 1'b0;
      end

      if (cmd.walk_rst) begin
         walk_in = '0;
         sum_in  = '0;
      end else begin
         if (cmd.walk_inc) begin
            walk_in = walk_ff + WKW'(1);
         end
         if (cmd.pre_wr) begin
            sum_in = sum_next;
         end
      end

      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         res_sel_in    = cmd.res_sel;
      end

      // load the output register from the read data that the result points at
      if (cmd.out_load) begin
         out_status_in = res_status_ff;
         case (res_sel_ff)
            VSEL_OFFSET: out_value_in = VAL_W'(off_rd_ff);
            VSEL_INCID:  out_value_in = VAL_W'(inc_rd_ff);
            default:     out_value_in = '0;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROWCNT_RESET;
         loaded_ff    <= '0;
         bad_ff       <= 1'b0;
         built_ff     <= 1'b0;
         walk_ff      <= '0;
      end else begin
         row_count_ff <= row_count_in;
         loaded_ff    <= loaded_in;
         bad_ff       <= bad_in;
         built_ff     <= built_in;
         walk_ff      <= walk_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      res_status_ff <= res_status_in;
      res_sel_ff    <= res_sel_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_read_value = out_value_ff;
   assign rsp_status     = out_status_ff;

   // Edge store: append on add, read by walk index during a build
   always_ff @(posedge clock) begin
      if (cmd.add_edge) begin
         edge_mem[EAW'(loaded_ff)] <= {RAW'(req_endpoint_a), RAW'(req_endpoint_b)};
      end
      if (cmd.edge_rd) begin
         {edge_a_ff, edge_b_ff} <= edge_mem[EAW'(walk_ff)];
      end
   end

   // Offset memory ports: clear sweep, count update, prefix sum and offset read
   always_comb begin
      off_re      = cmd.read_off | cmd.cnt_rd | cmd.pre_rd;
      off_rd_addr = RCW'(req_read_index);
      if (cmd.cnt_rd) begin
         off_rd_addr = end_up;
      end else if (cmd.pre_rd) begin
         off_rd_addr = walk_up;
      end

      off_we      = cmd.off_zero | cmd.cnt_wr | cmd.pre_wr;
      off_wr_addr = RCW'(walk_ff);
      off_wr_data = '0;
      if (cmd.cnt_wr) begin
         off_wr_addr = end_up;
         off_wr_data = off_rd_ff + OVW'(1);
      end else if (cmd.pre_wr) begin
         off_wr_addr = walk_up;
         off_wr_data = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem[off_wr_addr] <= off_wr_data;
      end
      if (off_re) begin
         off_rd_ff <= off_mem[off_rd_addr];
      end
   end

   // Cursor memory: seeded by the prefix pass, advanced by the scatter pass
   always_comb begin
      cur_we      = cmd.pre_wr | cmd.sct_wr;
      cur_wr_addr = RAW'(walk_ff);
      cur_wr_data = sum_ff;
      if (cmd.sct_wr) begin
         cur_wr_addr = end_row;
         cur_wr_data = cur_rd_ff + OVW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_wr_addr] <= cur_wr_data;
      end
      if (cmd.sct_rd) begin
         cur_rd_ff <= cur_mem[end_row];
      end
   end

   // Incidence memory: scatter writes the edge number at the cursor
   always_ff @(posedge clock) begin
      if (cmd.sct_wr) begin
         inc_mem[IAW'(cur_rd_ff)] <= EAW'(walk_ff);
      end
      if (cmd.read_inc) begin
         inc_rd_ff <= inc_mem[IAW'(req_read_index)];
      end
   end

endmodule

[rtl/elci_ctrl.sv]
// Controller of the incidence builder: command decode, build sequencing and
// the response valid flag. Uses elci_pkg for states, codes and the command structs.
`timescale 1ns / 1ps

module elci_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [elci_pkg::OP_W-1:0]   req_op,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   input  elci_pkg::stat_type          stat,
   output elci_pkg::cmd_type           cmd
);
   import elci_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in      = ST_EMIT;
               cmd.res_load  = 1'b1;
               cmd.res_status = STS_OK;
               cmd.res_sel   = VSEL_ZERO;
               unique case (op_type'(req_op))
                  OP_CLEAR: begin
                     cmd.clear_store = 1'b1;
                  end
                  OP_ADD: begin
                     if (stat.store_full) begin
                        cmd.mark_bad   = 1'b1;
                        cmd.res_status = STS_FULL;
                     end else if (stat.add_out_of_range) begin
                        cmd.mark_bad   = 1'b1;
                        cmd.res_status = STS_RANGE;
                     end else begin
                        cmd.add_edge = 1'b1;
                     end
                  end
                  OP_BUILD: begin
                     cmd.clr_built = 1'b1;
                     if (stat.bad_seen) begin
                        cmd.res_status = STS_INVALID;
                     end else begin
                        // start the clear sweep of the offsets
                        cmd.res_load = 1'b0;
                        cmd.walk_rst = 1'b1;
                        state_in     = ST_CLEAR;
                     end
                  end
                  OP_READ_OFF: begin
                     if (stat.off_idx_ok) begin
                        cmd.read_off = 1'b1;
                        cmd.res_sel  = VSEL_OFFSET;
                     end else begin
                        cmd.res_status = STS_INVALID;
                     end
                  end
                  OP_READ_INC: begin
                     if (stat.inc_idx_ok) begin
                        cmd.read_inc = 1'b1;
                        cmd.res_sel  = VSEL_INCID;
                     end else begin
                        cmd.res_status = STS_INVALID;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // hold the result until the output register frees up
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // zero offsets 0..rows
         ST_CLEAR: begin
            cmd.off_zero = 1'b1;
            if (stat.walk_at_rows) begin
               cmd.walk_rst = 1'b1;
               state_in     = ST_CNT_EDGE;
            end else begin
               cmd.walk_inc = 1'b1;
            end
         end

         // count incidences per row, checking each stored edge against rows
         ST_CNT_EDGE: begin
            if (stat.walk_at_edges) begin
               cmd.walk_rst = 1'b1;
               state_in     = ST_PRE_RD;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = ST_CNT_RD_A;
            end
         end
         ST_CNT_RD_A: begin
            if (stat.edge_out_of_range) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_RANGE;
               cmd.res_sel    = VSEL_ZERO;
               state_in       = ST_EMIT;
            end else begin
               cmd.end_sel = END_A;
               cmd.cnt_rd  = 1'b1;
               state_in    = ST_CNT_WR_A;
            end
         end
         ST_CNT_WR_A: begin
            cmd.end_sel = END_A;
            cmd.cnt_wr  = 1'b1;
            state_in    = ST_CNT_RD_B;
         end
         ST_CNT_RD_B: begin
            cmd.end_sel = END_B;
            cmd.cnt_rd  = 1'b1;
            state_in    = ST_CNT_WR_B;
         end
         ST_CNT_WR_B: begin
            cmd.end_sel  = END_B;
            cmd.cnt_wr   = 1'b1;
            cmd.walk_inc = 1'b1;
            state_in     = ST_CNT_EDGE;
         end

         // running sum over the counts, seeding the cursors
         ST_PRE_RD: begin
            if (stat.walk_at_rows) begin
               cmd.walk_rst = 1'b1;
               state_in     = ST_SCT_EDGE;
            end else begin
               cmd.pre_rd = 1'b1;
               state_in   = ST_PRE_WR;
            end
         end
         ST_PRE_WR: begin
            cmd.pre_wr   = 1'b1;
            cmd.walk_inc = 1'b1;
            state_in     = ST_PRE_RD;
         end

         // scatter edge numbers in ascending edge order
         ST_SCT_EDGE: begin
            if (stat.walk_at_edges) begin
               cmd.set_built  = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_OK;
               cmd.res_sel    = VSEL_ZERO;
               state_in       = ST_EMIT;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = ST_SCT_RD_A;
            end
         end
         ST_SCT_RD_A: begin
            cmd.end_sel = END_A;
            cmd.sct_rd  = 1'b1;
            state_in    = ST_SCT_WR_A;
         end
         ST_SCT_WR_A: begin
            cmd.end_sel = END_A;
            cmd.sct_wr  = 1'b1;
            state_in    = ST_SCT_RD_B;
         end
         ST_SCT_RD_B: begin
            cmd.end_sel = END_B;
            cmd.sct_rd  = 1'b1;
            state_in    = ST_SCT_WR_B;
         end
         ST_SCT_WR_B: begin
            cmd.end_sel  = END_B;
            cmd.sct_wr   = 1'b1;
            cmd.walk_inc = 1'b1;
            state_in     = ST_SCT_EDGE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/edge_list_to_csr_incidence.sv]
// Builds a compressed-row incidence table from an edge list. Send a clear, then
// one add beat per edge (two row endpoints); an out-of-range endpoint or a full
// store answers with an error and makes the next build fail. A build counts the
// incidences of each row, turns the counts into row offsets and scatters edge
// numbers so that each row lists its edges in ascending order, a self-loop twice.
// Read beats return one offset or one incidence entry. Every request beat gives
// exactly one response beat. For clear, add, read and unused codes the result
// is registered on acceptance and moves to the response register once that
// register is free. The offset, cursor and incidence memories have one read
// and one write port each, so in a build every endpoint takes a read state and
// a write state, the clear sweep visits one row per cycle and the prefix sweep
// takes a read and a write state per row. One request is in flight at a time;
// a finished response waits in its own register while the next one is taken.
// Top level: joins elci_ctrl and elci_dp; uses elci_pkg, elci_req_if, elci_rsp_if.
`timescale 1ns / 1ps

module edge_list_to_csr_incidence #(
   parameter int ROWS_MAX  = 1024,
   parameter int EDGES_MAX = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   elci_req_if.sink                      req_bus,
   elci_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_en,
   input  logic [elci_pkg::ROWCNT_W-1:0] csr_write_data
);
   import elci_pkg::*;

   cmd_type  dp_cmd;
   stat_type dp_stat;

   // Sequencer
   elci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // Storage and arithmetic
   elci_dp #(
      .ROWS_MAX  (ROWS_MAX),
      .EDGES_MAX (EDGES_MAX)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_endpoint_a (req_bus.endpoint_a),
      .req_endpoint_b (req_bus.endpoint_b),
      .req_read_index (req_bus.read_index),
      .cmd            (dp_cmd),
      .stat           (dp_stat),
      .rsp_read_value (rsp_bus.read_value),
      .rsp_status     (rsp_bus.status)
   );

   // The response register is never loaded over a beat that has not been taken
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response register loaded while a beat is pending");

   // An edge is never appended to a full store
   a_add_not_full: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.add_edge |-> !dp_stat.store_full)
      else $error("edge appended to a full store");

   // A table is never marked built after a rejected add
   a_built_clean: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.set_built |-> !dp_stat.bad_seen)
      else $error("table marked built after a rejected add");

   // One request in flight: no beat is taken in the cycle after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while the previous one is in flight");

endmodule
